// ----- hdl/lzw_pkg.sv -----
`default_nettype none
package lzw_pkg;

  // Dictionary hash table
  localparam int unsigned HASH_SLOTS    = 5003;
  localparam int unsigned SLOT_W        = $clog2(HASH_SLOTS);
  localparam int unsigned MAX_CODE_BITS = 12;

  // Code stream
  localparam int unsigned CODE_W  = 12;
  localparam int unsigned WIDTH_W = 4;
  localparam int unsigned NF_W    = 13;
  localparam int unsigned COUNT_W = 20;
  localparam int unsigned EPOCH_W = 8;
  localparam int unsigned KEY_W   = 20;
  localparam int unsigned ACC_W   = MAX_CODE_BITS + 7;
  localparam int unsigned CNT_W   = 5;

  localparam logic [CODE_W-1:0]  CODE_CLEAR  = 12'd256;
  localparam logic [CODE_W-1:0]  CODE_END    = 12'd257;
  localparam logic [NF_W-1:0]    FIRST_FREE  = 13'd258;
  localparam logic [WIDTH_W-1:0] START_WIDTH = 4'd9;
  localparam logic [NF_W-1:0]    START_LIMIT = 13'd511;
  localparam logic [WIDTH_W-1:0] MAX_WIDTH   = WIDTH_W'(MAX_CODE_BITS);
  localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
  localparam logic [COUNT_W-1:0] LIMIT_RESET = 20'd170000;

  // Token queue
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_t;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       final_byte;
  } out_t;

  // One code to be packed; flush marks the end code of a stream
  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [WIDTH_W-1:0] width;
    logic               flush;
  } token_t;

  // Hash table entry; live only when epoch matches the current dictionary
  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [KEY_W-1:0]   key;
    logic [CODE_W-1:0]  code;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

// ----- hdl/lzw_ram.sv -----
`default_nettype none
module lzw_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- hdl/lzw_front.sv -----
`default_nettype none
module lzw_front (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire lzw_pkg::in_t                     in_data_i,
  input  wire logic [lzw_pkg::COUNT_W-1:0]      limit_i,
  output logic                                  push_o,
  output lzw_pkg::token_t                       tok_o,
  input  wire logic                             full_i,
  output logic                                  ram_we_o,
  output logic [lzw_pkg::SLOT_W-1:0]            ram_waddr_o,
  output logic [lzw_pkg::ENTRY_W-1:0]           ram_wdata_o,
  output logic [lzw_pkg::SLOT_W-1:0]            ram_raddr_o,
  input  wire logic [lzw_pkg::ENTRY_W-1:0]      ram_rdata_i
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SWEEP    = 3'd1;
  localparam logic [2:0] S_PROBE    = 3'd2;
  localparam logic [2:0] S_MISS     = 3'd3;
  localparam logic [2:0] S_CLR      = 3'd4;
  localparam logic [2:0] S_TAIL_PRE = 3'd5;
  localparam logic [2:0] S_TAIL_END = 3'd6;

  localparam logic [lzw_pkg::SLOT_W-1:0] SLOTS = lzw_pkg::SLOT_W'(lzw_pkg::HASH_SLOTS);
  localparam logic [lzw_pkg::SLOT_W-1:0] LAST_SLOT =
    lzw_pkg::SLOT_W'(lzw_pkg::HASH_SLOTS - 1);

  logic [2:0]                     state_q, state_d;
  logic [7:0]                     sym_q, sym_d;
  logic                           last_q, last_d;
  logic [lzw_pkg::CODE_W-1:0]     prefix_q, prefix_d;
  logic [lzw_pkg::NF_W-1:0]       nf_q, nf_d;
  logic [lzw_pkg::WIDTH_W-1:0]    cw_q, cw_d;
  logic [lzw_pkg::NF_W-1:0]       wl_q, wl_d;
  logic [lzw_pkg::COUNT_W-1:0]    count_q, count_d;
  logic                           started_q, started_d;
  logic [lzw_pkg::EPOCH_W-1:0]    epoch_q, epoch_d;
  logic                           sweep_pend_q, sweep_pend_d;
  logic [lzw_pkg::SLOT_W-1:0]     sweep_q, sweep_d;
  logic [lzw_pkg::SLOT_W-1:0]     slot_q, slot_d;
  logic [lzw_pkg::SLOT_W-1:0]     disp_q, disp_d;
  logic                           first_q, first_d;

  logic [lzw_pkg::SLOT_W-1:0]     hash_slot, next_slot;
  logic [lzw_pkg::KEY_W-1:0]      key;
  lzw_pkg::entry_t                rd, wr;
  logic                           live, match;
  logic [lzw_pkg::WIDTH_W-1:0]    cw_n;
  logic [lzw_pkg::NF_W-1:0]       wl_n;
  logic                           grow;

  // Hash never exceeds 12 bits, so it is already below the slot count
  assign hash_slot = lzw_pkg::SLOT_W'({in_data_i.data_byte, 4'b0000} ^ prefix_q);
  assign next_slot = (slot_q >= disp_q) ? (slot_q - disp_q) : (slot_q + (SLOTS - disp_q));
  assign key       = {sym_q, prefix_q};
  assign rd        = lzw_pkg::entry_t'(ram_rdata_i);
  assign live      = (rd.epoch == epoch_q);
  assign match     = live && (rd.key == key);
  assign grow      = (nf_q == wl_q);
  assign cw_n      = grow ? (cw_q + 4'd1) : cw_q;
  assign wl_n      = grow ? {wl_q[lzw_pkg::NF_W-2:0], 1'b1} : wl_q;

  assign in_ready_o  = (state_q == S_IDLE) && !sweep_pend_q;
  assign ram_raddr_o = (state_q == S_IDLE) ? hash_slot : next_slot;
  assign ram_wdata_o = wr;

  always_comb begin
    state_d      = state_q;
    sym_d        = sym_q;
    last_d       = last_q;
    prefix_d     = prefix_q;
    nf_d         = nf_q;
    cw_d         = cw_q;
    wl_d         = wl_q;
    count_d      = count_q;
    started_d    = started_q;
    epoch_d      = epoch_q;
    sweep_pend_d = sweep_pend_q;
    sweep_d      = sweep_q;
    slot_d       = slot_q;
    disp_d       = disp_q;
    first_d      = first_q;
    push_o       = 1'b0;
    tok_o        = '0;
    ram_we_o     = 1'b0;
    ram_waddr_o  = slot_q;
    wr           = '0;

    unique case (state_q)
      S_IDLE: begin
        if (sweep_pend_q) begin
          state_d = S_SWEEP;
          sweep_d = '0;
        end else if (in_valid_i) begin
          sym_d  = in_data_i.data_byte;
          last_d = in_data_i.end_of_stream;
          if (!started_q) begin
            // First byte: clear code at start width, byte becomes prefix
            cw_d      = lzw_pkg::START_WIDTH;
            prefix_d  = lzw_pkg::CODE_W'(in_data_i.data_byte);
            started_d = 1'b1;
            state_d   = S_CLR;
          end else begin
            if (count_q != lzw_pkg::COUNT_MAX) begin
              count_d = count_q + 1'b1;
            end
            slot_d  = hash_slot;
            disp_d  = (hash_slot == '0) ? lzw_pkg::SLOT_W'(1) : (SLOTS - hash_slot);
            first_d = 1'b1;
            state_d = S_PROBE;
          end
        end
      end
      S_SWEEP: begin
        // Invalidate every entry (epoch zero is never current)
        ram_we_o    = 1'b1;
        ram_waddr_o = sweep_q;
        if (sweep_q == LAST_SLOT) begin
          sweep_pend_d = 1'b0;
          state_d      = S_IDLE;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end
      S_PROBE: begin
        if (match) begin
          prefix_d = rd.code;
          state_d  = last_q ? S_TAIL_PRE : S_IDLE;
        end else if (!live || (!first_q && rd.key == '0)) begin
          state_d = S_MISS;
        end else begin
          slot_d  = next_slot;
          first_d = 1'b0;
        end
      end
      S_MISS: begin
        if (!full_i) begin
          push_o   = 1'b1;
          tok_o    = '{code: prefix_q, width: cw_q, flush: 1'b0};
          prefix_d = lzw_pkg::CODE_W'(sym_q);
          wl_d     = wl_n;
          if (cw_n <= lzw_pkg::MAX_WIDTH && count_q <= limit_i) begin
            ram_we_o = 1'b1;
            wr       = '{epoch: epoch_q, key: key, code: nf_q[lzw_pkg::CODE_W-1:0]};
            nf_d     = nf_q + 1'b1;
            cw_d     = cw_n;
            state_d  = last_q ? S_TAIL_PRE : S_IDLE;
          end else begin
            cw_d    = (cw_n > lzw_pkg::MAX_WIDTH) ? lzw_pkg::MAX_WIDTH : cw_n;
            state_d = S_CLR;
          end
        end
      end
      S_CLR: begin
        if (!full_i) begin
          push_o  = 1'b1;
          tok_o   = '{code: lzw_pkg::CODE_CLEAR, width: cw_q, flush: 1'b0};
          // Dictionary restart: new epoch, sweep when the epoch wraps
          nf_d    = lzw_pkg::FIRST_FREE;
          cw_d    = lzw_pkg::START_WIDTH;
          wl_d    = lzw_pkg::START_LIMIT;
          count_d = '0;
          if (epoch_q == {lzw_pkg::EPOCH_W{1'b1}}) begin
            epoch_d      = lzw_pkg::EPOCH_W'(1);
            sweep_pend_d = 1'b1;
          end else begin
            epoch_d = epoch_q + 1'b1;
          end
          state_d = last_q ? S_TAIL_PRE : S_IDLE;
        end
      end
      S_TAIL_PRE: begin
        if (!full_i) begin
          push_o = 1'b1;
          tok_o  = '{code: prefix_q, width: cw_q, flush: 1'b0};
          if (grow && cw_q != lzw_pkg::MAX_WIDTH) begin
            cw_d = cw_q + 4'd1;
          end
          state_d = S_TAIL_END;
        end
      end
      S_TAIL_END: begin
        if (!full_i) begin
          push_o    = 1'b1;
          tok_o     = '{code: lzw_pkg::CODE_END, width: cw_q, flush: 1'b1};
          started_d = 1'b0;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      prefix_q     <= '0;
      nf_q         <= lzw_pkg::FIRST_FREE;
      cw_q         <= lzw_pkg::START_WIDTH;
      wl_q         <= lzw_pkg::START_LIMIT;
      count_q      <= '0;
      started_q    <= 1'b0;
      epoch_q      <= lzw_pkg::EPOCH_W'(1);
      sweep_pend_q <= 1'b1;
      sweep_q      <= '0;
      last_q       <= 1'b0;
      first_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      prefix_q     <= prefix_d;
      nf_q         <= nf_d;
      cw_q         <= cw_d;
      wl_q         <= wl_d;
      count_q      <= count_d;
      started_q    <= started_d;
      epoch_q      <= epoch_d;
      sweep_pend_q <= sweep_pend_d;
      sweep_q      <= sweep_d;
      last_q       <= last_d;
      first_q      <= first_d;
    end
  end

  // Probe datapath
  always_ff @(posedge clk_i) begin
    sym_q  <= sym_d;
    slot_q <= slot_d;
    disp_q <= disp_d;
  end

endmodule
`default_nettype wire

// ----- hdl/lzw_queue.sv -----
`default_nettype none
module lzw_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire lzw_pkg::token_t tok_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output lzw_pkg::token_t      tok_o,
  output logic                 empty_o
);

  lzw_pkg::token_t               buf_q [lzw_pkg::Q_DEPTH];
  logic [lzw_pkg::Q_PTR_W-1:0]   wptr_q, rptr_q;
  logic [lzw_pkg::Q_PTR_W:0]     cnt_q;

  assign full_o  = (cnt_q == (lzw_pkg::Q_PTR_W+1)'(lzw_pkg::Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign tok_o   = buf_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wptr_q] <= tok_i;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/lzw_back.sv -----
`default_nettype none
module lzw_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            tok_valid_i,
  input  wire lzw_pkg::token_t tok_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output lzw_pkg::out_t        out_data_o
);

  logic [lzw_pkg::ACC_W-1:0] acc_q, acc_d;
  logic [lzw_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                      flush_q, flush_d;
  logic                      ov_q, ov_d;
  lzw_pkg::out_t             od_q, od_d;
  logic                      can_emit;
  logic [lzw_pkg::CNT_W-1:0] rem;
  logic [lzw_pkg::ACC_W-1:0] shifted, code_m;

  assign can_emit    = !ov_q || out_ready_i;
  assign rem         = cnt_q - 5'd8;
  assign shifted     = acc_q >> rem;
  assign code_m      = lzw_pkg::ACC_W'(tok_i.code)
                       & ((lzw_pkg::ACC_W'(1) << tok_i.width) - 1'b1);
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  // Bit packer: one byte out or one code in per cycle, unless the output is stalled or no code waits
  always_comb begin
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    flush_d = flush_q;
    ov_d    = ov_q && !out_ready_i;
    od_d    = od_q;
    pop_o   = 1'b0;
    if (cnt_q >= 5'd8) begin
      if (can_emit) begin
        ov_d  = 1'b1;
        od_d  = '{packed_byte: shifted[7:0], final_byte: flush_q && (cnt_q == 5'd8)};
        cnt_d = rem;
        acc_d = acc_q & ((lzw_pkg::ACC_W'(1) << rem) - 1'b1);
        if (cnt_q == 5'd8) begin
          flush_d = 1'b0;
        end
      end
    end else if (flush_q) begin
      // Zero-padded last byte
      if (can_emit) begin
        ov_d    = 1'b1;
        od_d    = '{packed_byte: acc_q[7:0] << (4'd8 - cnt_q[3:0]), final_byte: 1'b1};
        cnt_d   = '0;
        acc_d   = '0;
        flush_d = 1'b0;
      end
    end else if (tok_valid_i) begin
      pop_o   = 1'b1;
      acc_d   = (acc_q << tok_i.width) | code_m;
      cnt_d   = cnt_q + lzw_pkg::CNT_W'(tok_i.width);
      flush_d = tok_i.flush;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      cnt_q   <= '0;
      flush_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      flush_q <= flush_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    od_q <= od_d;
  end

endmodule
`default_nettype wire

// ----- hdl/lzw_stream_compressor.sv -----
// Front end: a later byte is accepted, then the hash table is read, with one more probe
// per collision, and a miss queues a code; a first byte queues a clear code. A full
// queue stalls the front end, which takes no new byte until it is done with the last.
// The packer takes codes in and puts bytes out one at a time, and holds while the output
// is stalled. Reset: async active low; the table sweep after reset and after every 255th
// dictionary restart keeps in_ready_o low until every slot of the table has been written.
`default_nettype none
module lzw_stream_compressor (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire lzw_pkg::in_t                in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output lzw_pkg::out_t                    out_data_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [lzw_pkg::COUNT_W-1:0] cfg_wdata_i
);

  logic [lzw_pkg::COUNT_W-1:0] limit_q;
  logic                        push, full, pop, empty;
  lzw_pkg::token_t             tok_in, tok_out;
  logic                        ram_we;
  logic [lzw_pkg::SLOT_W-1:0]  ram_waddr, ram_raddr;
  logic [lzw_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;

  // Symbol limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= lzw_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  lzw_ram #(
    .Width (lzw_pkg::ENTRY_W),
    .Depth (lzw_pkg::HASH_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lzw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .limit_i     (limit_q),
    .push_o      (push),
    .tok_o       (tok_in),
    .full_i      (full),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  lzw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .tok_i   (tok_in),
    .full_o  (full),
    .pop_i   (pop),
    .tok_o   (tok_out),
    .empty_o (empty)
  );

  lzw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (!empty),
    .tok_i       (tok_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

// ----- hdl/lzw_checker.sv -----
`default_nettype none
module lzw_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_o,
  input wire lzw_pkg::in_t                in_data_i,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire lzw_pkg::out_t               out_data_o,
  input wire logic                        cfg_we_i,
  input wire logic [lzw_pkg::COUNT_W-1:0] cfg_wdata_i
);

  logic       seen_q;
  logic [7:0] open_q;
  logic       in_acc, last_in, final_out;

  assign in_acc    = in_valid_i && in_ready_o;
  assign last_in   = in_acc && in_data_i.end_of_stream;
  assign final_out = out_valid_o && out_ready_i && out_data_o.final_byte;

  // Streams ended at the input whose final byte is still due
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
      open_q <= '0;
    end else begin
      if (in_acc) begin
        seen_q <= 1'b1;
      end
      if (last_in && !final_out && open_q != 8'hFF) begin
        open_q <= open_q + 1'b1;
      end else if (final_out && !last_in && open_q != 8'h00) begin
        open_q <= open_q - 1'b1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output item dropped or changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> seen_q)
    else $error("output item before any input item");

  a_final_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    final_out |-> open_q != 8'h00)
    else $error("final byte without an ended stream");

  // Limit is only rewritten while no output item is pending
  a_cfg_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> !out_valid_o && !$isunknown(cfg_wdata_i))
    else $error("limit written while output pending");

endmodule

bind lzw_stream_compressor lzw_checker u_lzw_checker (.*);
`default_nettype wire
